[rtl/core/dts_pkg.sv]
// Package for the depth-first topological sort block.
// Holds sizing constants, the front-to-back transfer record and the back-end state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

    localparam int MAX_NODES   = 32;
    localparam int ROW_W       = 32;
    localparam int OUT_W       = 5;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ROW_W-1:0]  row_bits;
        logic [NODE_W-1:0] idx;
        logic [CNT_W-1:0]  count;
        logic              wr;
        logic              last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_EXPAND,
        S_POP,
        S_EMIT_RD,
        S_EMIT
    } t_back_state;

endpackage

`default_nettype wire

[rtl/core/dfs_topological_sort.sv]
// Top level of the depth-first topological sort block.
// Instantiates dts_front, dts_cmd_q and dts_back; uses dts_pkg.
//
// Channel   Handshake            Payload
// input     start & !busy        i_row_bits, i_last_row
// result    o_strobe (1 cycle)   o_node_index, o_last_out
//
// Rows load through a two-entry command queue, one per cycle while busy (queue full) is low.
// On the last row the back end searches: a push is an EXPAND step, a pop passes through POP
// back to EXPAND, a new root goes through ROOT; then it emits one result per cycle. Adjacency
// and stack memory reads are registered. Rows for the next graph queue up during the search.
// Synchronous active-low reset clears all control state; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module dfs_topological_sort (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [dts_pkg::ROW_W-1:0] i_row_bits,
    input  wire logic                      i_last_row,
    output logic                           o_strobe,
    output logic [dts_pkg::OUT_W-1:0]      o_node_index,
    output logic                           o_last_out
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    dts_pkg::t_cmd front_cmd;
    dts_pkg::t_cmd head_cmd;

    assign busy = full;

    dts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_full     (full),
        .i_row_bits (i_row_bits),
        .i_last_row (i_last_row),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    dts_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    dts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_node_index (o_node_index),
        .o_last_out   (o_last_out)
    );

endmodule

`default_nettype wire

[rtl/core/dts_front.sv]
// Front end: takes row transfers, tracks the row count and builds queue commands.
// Depends on dts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dts_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic                   i_full,
    input  wire logic [dts_pkg::ROW_W-1:0] i_row_bits,
    input  wire logic                   i_last_row,
    output logic                        o_push,
    output dts_pkg::t_cmd               o_cmd
);

    logic [dts_pkg::CNT_W-1:0]  r_rows;
    logic [dts_pkg::CNT_W-1:0]  n_rows;
    logic                       room;
    logic [dts_pkg::NODE_W-1:0] idx;
    logic [dts_pkg::CNT_W-1:0]  count;

    assign o_push = i_start & ~i_full;
    assign room   = (r_rows < dts_pkg::CNT_W'(dts_pkg::MAX_NODES));
    assign idx    = r_rows[dts_pkg::NODE_W-1:0];
    assign count  = r_rows + dts_pkg::CNT_W'(room);

    always_comb begin
        o_cmd.row_bits = i_row_bits & ~(dts_pkg::ROW_W'(1) << idx);
        o_cmd.idx      = idx;
        o_cmd.count    = count;
        o_cmd.wr       = room;
        o_cmd.last     = i_last_row;
        n_rows         = r_rows;
        if (o_push) begin
            n_rows = i_last_row ? '0 : count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else begin
            r_rows <= n_rows;
        end
    end

endmodule

`default_nettype wire

[rtl/core/dts_cmd_q.sv]
// Short command queue between front and back ends.
// Depends on dts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dts_cmd_q (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dts_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output dts_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);

    dts_pkg::t_cmd               r_mem [dts_pkg::QUEUE_DEPTH];
    logic [dts_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [dts_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [dts_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == dts_pkg::QCNT_W'(dts_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + dts_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + dts_pkg::QPTR_W'(1);
            end
            r_count <= r_count + dts_pkg::QCNT_W'(i_push) - dts_pkg::QCNT_W'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

[rtl/core/dts_back.sv]
// Back end: adjacency store, depth-first search with explicit stack, reversed post-order emit.
// Depends on dts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dts_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire dts_pkg::t_cmd          i_cmd,
    input  wire logic                   i_empty,
    output logic                        o_pop,
    output logic                        o_strobe,
    output logic [dts_pkg::OUT_W-1:0]   o_node_index,
    output logic                        o_last_out
);

    localparam int N = dts_pkg::MAX_NODES;
    localparam int NW = dts_pkg::NODE_W;
    localparam int CW = dts_pkg::CNT_W;
    localparam int RW = dts_pkg::ROW_W;

    function automatic logic [NW-1:0] f_lowest(input logic [N-1:0] v);
        logic [NW-1:0] res;
        res = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = NW'(i);
            end
        end
        return res;
    endfunction

    function automatic logic [N-1:0] f_valid(input logic [CW-1:0] cnt);
        logic [N-1:0] m;
        m = '0;
        for (int i = 0; i < N; i++) begin
            m[i] = (CW'(i) < cnt);
        end
        return m;
    endfunction

    dts_pkg::t_back_state r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic [N-1:0]  r_unvis, n_unvis;
    logic [NW-1:0] r_top, n_top;
    logic [CW-1:0] r_depth, n_depth;
    logic [CW-1:0] r_post_cnt, n_post_cnt;
    logic [CW-1:0] r_ptr, n_ptr;

    logic [RW-1:0] adj_mem [N];
    logic [NW-1:0] stk_mem [N];
    logic [NW-1:0] post_mem [N];
    logic [RW-1:0] r_adj_rd;
    logic [NW-1:0] r_stk_rd;
    logic [NW-1:0] r_post_rd;

    logic          adj_we;
    logic [NW-1:0] adj_waddr;
    logic [NW-1:0] adj_raddr;
    logic          stk_we;
    logic [NW-1:0] stk_waddr;
    logic [NW-1:0] stk_raddr;
    logic          post_we;
    logic [NW-1:0] post_waddr;
    logic [NW-1:0] post_raddr;

    logic [N-1:0]  cand;
    logic [NW-1:0] pick;
    logic [CW-1:0] depth_m1;
    logic [CW-1:0] depth_m2;
    logic [CW-1:0] ptr_m1;

    assign cand     = N'(r_adj_rd) & r_unvis;
    assign pick     = f_lowest((r_state == dts_pkg::S_ROOT) ? r_unvis : cand);
    assign depth_m1 = r_depth - CW'(1);
    assign depth_m2 = r_depth - CW'(2);
    assign ptr_m1   = r_ptr - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_unvis      = r_unvis;
        n_top        = r_top;
        n_depth      = r_depth;
        n_post_cnt   = r_post_cnt;
        n_ptr        = r_ptr;
        o_pop        = 1'b0;
        o_strobe     = 1'b0;
        o_node_index = dts_pkg::OUT_W'(r_post_rd);
        o_last_out   = 1'b0;
        adj_we       = 1'b0;
        adj_waddr    = i_cmd.idx;
        adj_raddr    = r_top;
        stk_we       = 1'b0;
        stk_waddr    = depth_m1[NW-1:0];
        stk_raddr    = depth_m2[NW-1:0];
        post_we      = 1'b0;
        post_waddr   = r_post_cnt[NW-1:0];
        post_raddr   = ptr_m1[NW-1:0];
        case (r_state)
            dts_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    adj_we = i_cmd.wr;
                    if (i_cmd.last) begin
                        n_n        = i_cmd.count;
                        n_unvis    = f_valid(i_cmd.count);
                        n_post_cnt = '0;
                        n_depth    = '0;
                        n_state    = dts_pkg::S_ROOT;
                    end
                end
            end
            dts_pkg::S_ROOT: begin
                if (r_unvis != '0) begin
                    n_unvis[pick] = 1'b0;
                    n_top         = pick;
                    n_depth       = CW'(1);
                    adj_raddr     = pick;
                    n_state       = dts_pkg::S_EXPAND;
                end else begin
                    n_ptr   = r_post_cnt;
                    n_state = dts_pkg::S_EMIT_RD;
                end
            end
            dts_pkg::S_EXPAND: begin
                if (cand != '0 && r_depth < CW'(N)) begin
                    stk_we        = 1'b1;
                    n_top         = pick;
                    n_unvis[pick] = 1'b0;
                    n_depth       = r_depth + CW'(1);
                    adj_raddr     = pick;
                end else begin
                    post_we    = 1'b1;
                    n_post_cnt = r_post_cnt + CW'(1);
                    n_depth    = depth_m1;
                    if (r_depth == CW'(1)) begin
                        n_state = dts_pkg::S_ROOT;
                    end else begin
                        n_state = dts_pkg::S_POP;
                    end
                end
            end
            dts_pkg::S_POP: begin
                n_top     = r_stk_rd;
                adj_raddr = r_stk_rd;
                n_state   = dts_pkg::S_EXPAND;
            end
            dts_pkg::S_EMIT_RD: begin
                n_ptr   = ptr_m1;
                n_state = dts_pkg::S_EMIT;
            end
            dts_pkg::S_EMIT: begin
                o_strobe   = 1'b1;
                o_last_out = (r_ptr == '0);
                if (r_ptr != '0) begin
                    n_ptr = ptr_m1;
                end else begin
                    n_state = dts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            adj_mem[adj_waddr] <= i_cmd.row_bits;
        end
        r_adj_rd <= adj_mem[adj_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= r_top;
        end
        r_stk_rd <= stk_mem[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (post_we) begin
            post_mem[post_waddr] <= r_top;
        end
        r_post_rd <= post_mem[post_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dts_pkg::S_IDLE;
            r_n        <= '0;
            r_unvis    <= '0;
            r_top      <= '0;
            r_depth    <= '0;
            r_post_cnt <= '0;
            r_ptr      <= '0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_unvis    <= n_unvis;
            r_top      <= n_top;
            r_depth    <= n_depth;
            r_post_cnt <= n_post_cnt;
            r_ptr      <= n_ptr;
        end
    end

`ifndef SYNTHESIS
    a_root_empty_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dts_pkg::S_ROOT) |-> (r_depth == '0))
        else $error("root search with non-empty stack");
    a_post_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dts_pkg::S_IDLE) |-> (r_post_cnt <= r_n))
        else $error("post-order count exceeds node count");
    a_all_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dts_pkg::S_ROOT && r_unvis == '0) |-> (r_post_cnt == r_n))
        else $error("search finished without recording every node");
    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_out) |=> (r_state == dts_pkg::S_IDLE))
        else $error("emit did not return to idle after last node");
`endif

endmodule

`default_nettype wire
